### src/first_fit_contiguous_sector_allocator_unit_defines.svh
// Assertion macros used by the allocator control RTL
`ifndef FIRST_FIT_CONTIGUOUS_SECTOR_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_CONTIGUOUS_SECTOR_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define FFCSA_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("ffcsa: same-cycle check failed");
`define FFCSA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("ffcsa: next-cycle check failed");
`else
`define FFCSA_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define FFCSA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

### src/ffcsa_pkg.sv
package ffcsa_pkg;

    localparam int START_W     = 16;
    localparam int SECT_W      = 14;
    localparam int RUN_START_W = 32;
    localparam int BYTES_W     = 23;
    localparam int OUT_START_W = 17;

    localparam int SECTOR_BYTES = 512;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int NEED_W       = BYTES_W + 1 - SECTOR_SHIFT;

    localparam logic [SECT_W-1:0]  COUNT_MAX = {SECT_W{1'b1}};

    localparam logic [START_W-1:0] RESET_REGION_START   = 16'd428;
    localparam logic [SECT_W-1:0]  RESET_REGION_SECTORS = 14'd7764;

    // Configuration register indexes
    localparam logic CFG_REGION_START   = 1'b0;
    localparam logic CFG_REGION_SECTORS = 1'b1;

    // Opcodes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;

    typedef struct packed {
        logic                   found;
        logic [OUT_START_W-1:0] start_sector;
        logic [SECT_W-1:0]      sector_count;
    } res_t;

endpackage

### src/first_fit_contiguous_sector_allocator_unit.sv
// Operations: clear zeroes every bitmap word in turn; mark reads and rewrites each bitmap
//   word that the run touches and skips to the response when it touches none; allocate
//   scans the region bit by bit until a free run is found or the scan reaches the region
//   end, and skips the scan when the request exceeds the region. Items run one at a time:
//   start is accepted only while idle, at the earliest in the cycle after done.
// Reset: rst_n resets the sequencer and the configuration registers, then a clearing pass
//   over every bitmap word runs with busy high. done pulses one cycle; the receiver
//   cannot stall.
module first_fit_contiguous_sector_allocator_unit
    import ffcsa_pkg::*;
#(
    parameter int MAX_DATA_SECTORS = 8192
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             opcode,
    input  logic [RUN_START_W-1:0] run_start,
    input  logic [SECT_W-1:0]      run_count,
    input  logic [BYTES_W-1:0]     byte_size,
    output logic                   done,
    output logic                   found,
    output logic [OUT_START_W-1:0] start_sector,
    output logic [SECT_W-1:0]      sector_count,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_addr,
    input  logic [START_W-1:0]     cfg_data
);

    localparam int SIZE_MAX  = (MAX_DATA_SECTORS < (1 << SECT_W) - 1) ?
                               MAX_DATA_SECTORS : (1 << SECT_W) - 1;
    localparam int SZ_W      = $clog2(SIZE_MAX + 1);
    localparam int WORD_BITS = (SIZE_MAX < 32) ? 16 : 32;
    localparam int WORDS     = (SIZE_MAX + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [START_W-1:0]   region_start_reg;
    logic [SECT_W-1:0]    region_sectors_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [WADDR_W-1:0]   mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;
    res_t                 res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg   <= RESET_REGION_START;
            region_sectors_reg <= RESET_REGION_SECTORS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                CFG_REGION_START:   region_start_reg   <= cfg_data;
                CFG_REGION_SECTORS: region_sectors_reg <= cfg_data[SECT_W-1:0];
            endcase
        end
    end

    ffcsa_ctrl #(
        .MAX_DATA_SECTORS (MAX_DATA_SECTORS),
        .SIZE_MAX         (SIZE_MAX),
        .SZ_W             (SZ_W),
        .WORD_BITS        (WORD_BITS),
        .WORDS            (WORDS),
        .WADDR_W          (WADDR_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .run_start      (run_start),
        .run_count      (run_count),
        .byte_size      (byte_size),
        .region_start   (region_start_reg),
        .region_sectors (region_sectors_reg),
        .mem_we         (mem_we),
        .mem_re         (mem_re),
        .mem_addr       (mem_addr),
        .mem_wdata      (mem_wdata),
        .mem_rdata      (mem_rdata),
        .done           (done),
        .res            (res)
    );

    ffcsa_bitmap_mem #(
        .WORDS     (WORDS),
        .WORD_BITS (WORD_BITS),
        .WADDR_W   (WADDR_W)
    ) u_bitmap (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign found        = res.found;
    assign start_sector = res.start_sector;
    assign sector_count = res.sector_count;

endmodule

### src/ffcsa_bitmap_mem.sv
module ffcsa_bitmap_mem #(
    parameter int WORDS     = 256,
    parameter int WORD_BITS = 32,
    parameter int WADDR_W   = 8
)(
    input  logic                 clk,
    input  logic                 we,
    input  logic                 re,
    input  logic [WADDR_W-1:0]   addr,
    input  logic [WORD_BITS-1:0] wdata,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/ffcsa_ctrl.sv
`include "first_fit_contiguous_sector_allocator_unit_defines.svh"

module ffcsa_ctrl
    import ffcsa_pkg::*;
#(
    parameter int MAX_DATA_SECTORS = 8192,
    parameter int SIZE_MAX         = 8192,
    parameter int SZ_W             = 14,
    parameter int WORD_BITS        = 32,
    parameter int WORDS            = 256,
    parameter int WADDR_W          = 8
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             opcode,
    input  logic [RUN_START_W-1:0] run_start,
    input  logic [SECT_W-1:0]      run_count,
    input  logic [BYTES_W-1:0]     byte_size,
    input  logic [START_W-1:0]     region_start,
    input  logic [SECT_W-1:0]      region_sectors,
    output logic                   mem_we,
    output logic                   mem_re,
    output logic [WADDR_W-1:0]     mem_addr,
    output logic [WORD_BITS-1:0]   mem_wdata,
    input  logic [WORD_BITS-1:0]   mem_rdata,
    output logic                   done,
    output res_t                   res
);

    localparam int OFF_W = $clog2(WORD_BITS);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CLR     = 3'd1;
    localparam logic [2:0] S_MK_SET  = 3'd2;
    localparam logic [2:0] S_MK_RD   = 3'd3;
    localparam logic [2:0] S_MK_WR   = 3'd4;
    localparam logic [2:0] S_SR_CHK  = 3'd5;
    localparam logic [2:0] S_SR_SCAN = 3'd6;
    localparam logic [2:0] S_RESP    = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic                   boot_reg, boot_next;
    logic [SZ_W-1:0]        pos_reg, pos_next;
    logic [SZ_W-1:0]        run_reg, run_next;
    logic [SZ_W-1:0]        lo_reg, lo_next;
    logic [SZ_W-1:0]        hi_reg, hi_next;
    logic [RUN_START_W-1:0] rel_reg, rel_next;
    logic [SECT_W-1:0]      cnt_reg, cnt_next;
    logic [NEED_W-1:0]      need_reg, need_next;
    logic [OUT_START_W-1:0] off_reg, off_next;
    res_t                   res_reg, res_next;

    logic [SZ_W-1:0]        size;
    logic [BYTES_W:0]       bytes_up;
    logic [NEED_W-1:0]      need_raw;
    logic [NEED_W-1:0]      need_in;
    logic [SECT_W-1:0]      cnt_sat;
    logic [RUN_START_W:0]   end33;
    logic [RUN_START_W-1:0] lo32;
    logic [SZ_W-1:0]        lo_c;
    logic [SZ_W-1:0]        hi_c;
    logic [SZ_W:0]          pos_step;
    logic [NEED_W-1:0]      run_inc;
    logic                   cur_bit;
    logic [WADDR_W-1:0]     word_addr;
    logic [WORD_BITS-1:0]   mark_mask;
    logic [SZ_W-1:0]        bit_idx;

    // Region size saturated at the bitmap depth
    assign size = (32'(region_sectors) > SIZE_MAX) ? SZ_W'(SIZE_MAX) : SZ_W'(region_sectors);

    // Round bytes up to whole sectors, never below one
    assign bytes_up = {1'b0, byte_size} + (BYTES_W + 1)'(SECTOR_BYTES - 1);
    assign need_raw = bytes_up[BYTES_W:SECTOR_SHIFT];
    assign need_in  = (need_raw == '0) ? NEED_W'(1) : need_raw;
    assign cnt_sat  = (32'(run_count) > MAX_DATA_SECTORS) ?
                      SECT_W'(MAX_DATA_SECTORS) : run_count;

    // A wrapped run covers the bottom of the region up to its wrapped end
    assign end33 = {1'b0, rel_reg} + (RUN_START_W + 1)'(cnt_reg);
    assign lo32  = end33[RUN_START_W] ? '0 : rel_reg;
    assign lo_c  = (lo32 >= RUN_START_W'(size)) ? size : lo32[SZ_W-1:0];
    assign hi_c  = (end33[RUN_START_W-1:0] >= RUN_START_W'(size)) ?
                   size : end33[SZ_W-1:0];

    assign pos_step  = {1'b0, pos_reg} + (SZ_W + 1)'(WORD_BITS);
    assign run_inc   = NEED_W'(run_reg) + NEED_W'(1);
    assign cur_bit   = mem_rdata[pos_reg[OFF_W-1:0]];
    assign word_addr = pos_reg[OFF_W +: WADDR_W];

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            bit_idx      = {pos_reg[SZ_W-1:OFF_W], OFF_W'(b)};
            mark_mask[b] = (bit_idx >= lo_reg) && (bit_idx < hi_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        boot_next  = boot_reg;
        pos_next   = pos_reg;
        run_next   = run_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        rel_next   = rel_reg;
        cnt_next   = cnt_reg;
        need_next  = need_reg;
        off_next   = off_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = word_addr;
        mem_wdata  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rel_next              = run_start - RUN_START_W'(region_start);
                    cnt_next              = cnt_sat;
                    need_next             = need_in;
                    pos_next              = '0;
                    res_next.found        = 1'b0;
                    res_next.start_sector = OUT_START_W'(region_start);
                    res_next.sector_count = '0;
                    case (opcode)
                        OP_CLEAR: state_next = S_CLR;
                        OP_MARK:  state_next = S_MK_SET;
                        OP_ALLOC:
                        begin
                            state_next = S_SR_CHK;
                            res_next.sector_count = (need_in > NEED_W'(COUNT_MAX)) ?
                                                    COUNT_MAX : need_in[SECT_W-1:0];
                        end
                        default:  state_next = S_RESP;
                    endcase
                end
            end
            S_CLR:
            begin
                mem_we   = 1'b1;
                pos_next = pos_step[SZ_W-1:0];
                if (word_addr == WADDR_W'(WORDS - 1))
                begin
                    pos_next   = '0;
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_RESP;
                end
            end
            S_MK_SET:
            begin
                lo_next    = lo_c;
                hi_next    = hi_c;
                pos_next   = {lo_c[SZ_W-1:OFF_W], OFF_W'(0)};
                state_next = S_MK_RD;
            end
            S_MK_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_re     = 1'b1;
                    state_next = S_MK_WR;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_MK_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata | mark_mask;
                if (pos_step >= {1'b0, hi_reg})
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    pos_next   = pos_step[SZ_W-1:0];
                    state_next = S_MK_RD;
                end
            end
            S_SR_CHK:
            begin
                off_next = OUT_START_W'(region_start) + OUT_START_W'(1)
                           - OUT_START_W'(need_reg);
                if (need_reg > NEED_W'(size))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    // Fetch the first word ahead of the scan
                    mem_re     = 1'b1;
                    mem_addr   = '0;
                    pos_next   = '0;
                    run_next   = '0;
                    state_next = S_SR_SCAN;
                end
            end
            S_SR_SCAN:
            begin
                mem_addr = word_addr + WADDR_W'(1);
                if (pos_reg == size)
                begin
                    state_next = S_RESP;
                end
                else if (cur_bit)
                begin
                    run_next = '0;
                    pos_next = pos_reg + SZ_W'(1);
                    mem_re   = (pos_reg[OFF_W-1:0] == {OFF_W{1'b1}});
                end
                else if (run_inc == need_reg)
                begin
                    res_next.found        = 1'b1;
                    res_next.start_sector = off_reg + OUT_START_W'(pos_reg);
                    state_next            = S_RESP;
                end
                else
                begin
                    run_next = run_inc[SZ_W-1:0];
                    pos_next = pos_reg + SZ_W'(1);
                    // Prefetch the next word while the last bit is checked
                    mem_re   = (pos_reg[OFF_W-1:0] == {OFF_W{1'b1}});
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            boot_reg  <= 1'b1;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            boot_reg  <= boot_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg  <= run_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        rel_reg  <= rel_next;
        cnt_reg  <= cnt_next;
        need_reg <= need_next;
        off_reg  <= off_next;
        res_reg  <= res_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);
    assign res  = res_reg;

    `FFCSA_ASSERT_IMPL(a_one_port, clk, rst_n, mem_we, !mem_re)
    `FFCSA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `FFCSA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `FFCSA_ASSERT_IMPL(a_found_count, clk, rst_n, done && res.found, res.sector_count != '0)
    `FFCSA_ASSERT_IMPL(a_run_below_need, clk, rst_n, state_reg == S_SR_SCAN,
                       NEED_W'(run_reg) < need_reg)

endmodule
